/* design/bba_pkg.sv */
package bba_pkg;

	localparam int SIZE_W = 14;
	localparam int OFF_W = 13;
	localparam int LVL_W = 4;
	localparam int CNT_W = 9;
	localparam int STAT_W = 2;
	localparam int HDR_W = 8;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [OFF_W-1:0] offset_t;
	typedef logic [LVL_W-1:0] level_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [HDR_W-1:0] header_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_TOO_LARGE = 2'd1;
	localparam status_t ST_NO_FREE = 2'd2;
	localparam status_t ST_BAD_FREE = 2'd3;

	localparam logic [APB_AW-1:0] REG_HEADER = 2'd0;
	localparam header_t HDR_RESET = 8'd32;

endpackage

/* design/bba_if.sv */
interface bba_req_if;
	logic valid;
	logic ready;
	logic command;
	bba_pkg::size_t request_size;
	bba_pkg::offset_t free_offset;

	modport source(output valid, command, request_size, free_offset, input ready);
	modport sink(input valid, command, request_size, free_offset, output ready);
endinterface

interface bba_rsp_if;
	logic valid;
	logic ready;
	bba_pkg::status_t status;
	bba_pkg::offset_t block_offset;
	bba_pkg::level_t block_level;
	bba_pkg::count_t blocks_in_use;

	modport source(output valid, status, block_offset, block_level, blocks_in_use,
		input ready);
	modport sink(input valid, status, block_offset, block_level, blocks_in_use,
		output ready);
endinterface

/* design/bba_ram.sv */
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/buddy_block_allocator_core.sv */
// channel   direction  handshake     payload
// req       in         valid/ready   command, request_size, free_offset
// rsp       out        valid/ready   status, block_offset, block_level, blocks_in_use
// apb       in         psel/penable  header_bytes at byte address 0
//
// one request at a time, one tree level per step through the node memory
// allocate: root check, descent, split down to the requested level, ascent; errors skip to the response
// free: level lookup, a merge per free buddy, ascent updating masks; errors skip to the response
// after reset a clearing pass over every node mask and level entry runs with req.ready low
// a finished response waits in the output register; req.ready returns once it is queued
module buddy_block_allocator_core #(
	parameter int LEVEL_COUNT = 9,
	parameter int UNIT_BITS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bba_req_if.sink                      req,
	bba_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bba_pkg::APB_AW-1:0]   paddr,
	input  logic [bba_pkg::APB_DW-1:0]   pwdata,
	output logic [bba_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	localparam int RW = LEVEL_COUNT + UNIT_BITS;
	localparam int NODE_COUNT = (1 << LEVEL_COUNT) - 1;
	localparam int UNIT_COUNT = 1 << (LEVEL_COUNT - 1);
	localparam int AW = LEVEL_COUNT;
	localparam int IW = LEVEL_COUNT - 1;
	localparam int MW = LEVEL_COUNT;
	localparam int LW = $clog2(LEVEL_COUNT + 1);
	localparam int CW = $clog2(UNIT_COUNT + 1);
	localparam int TW = (RW + 1 > bba_pkg::SIZE_W + 1) ? RW + 1 : bba_pkg::SIZE_W + 1;
	localparam int OW = bba_pkg::OFF_W;
	localparam logic [LW-1:0] TOP_LVL = LW'(LEVEL_COUNT);
	localparam logic [OW-1:0] ALIGN_MASK = OW'((1 << (UNIT_BITS + 1)) - 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_AEV  = 4'd2;
	localparam logic [3:0] S_DESC = 4'd3;
	localparam logic [3:0] S_SPL  = 4'd4;
	localparam logic [3:0] S_SPR  = 4'd5;
	localparam logic [3:0] S_ASCR = 4'd6;
	localparam logic [3:0] S_ASC  = 4'd7;
	localparam logic [3:0] S_FEV  = 4'd8;
	localparam logic [3:0] S_CRD  = 4'd9;
	localparam logic [3:0] S_CEV  = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	function automatic logic [AW-1:0] node_addr(input logic [LW-1:0] lv,
		input logic [IW-1:0] k);
		logic [AW:0] one_sh;
		one_sh = (AW + 1)'(1) << (TOP_LVL - lv);
		return AW'(one_sh - (AW + 1)'(1)) + AW'(k);
	endfunction

	function automatic logic [MW-1:0] lvl_bit(input logic [LW-1:0] lv);
		return MW'(1) << (lv - LW'(1));
	endfunction

	// control state
	logic [3:0]           state_q, state_d;
	logic [AW-1:0]        clr_q;
	bba_pkg::header_t     header_q;
	logic [CW-1:0]        cnt_q;
	logic                 rsp_valid_q;

	// work registers
	logic [LW-1:0]        need_q, fl_q, lvl_q;
	logic [IW-1:0]        idx_q, fidx_q;
	logic [MW-1:0]        mask_q;
	bba_pkg::status_t     res_st_q;
	logic [OW-1:0]        res_off_q;
	logic [LW-1:0]        res_lvl_q;
	bba_pkg::status_t     out_st_q;
	logic [OW-1:0]        out_off_q;
	logic [LW-1:0]        out_lvl_q;
	logic [CW-1:0]        out_cnt_q;

	// memory ports
	logic                 m_we;
	logic [AW-1:0]        m_waddr, m_raddr;
	logic [MW-1:0]        m_wd, m_rdata;
	logic [LW-1:0]        wr_lv, rd_lv;
	logic [IW-1:0]        wr_k, rd_k;
	logic                 g_we;
	logic [IW-1:0]        g_waddr, g_raddr;
	logic [LW-1:0]        g_wdata, g_rdata;

	// shared decode
	logic                 accept, load;
	logic [TW-1:0]        total;
	logic [LW-1:0]        need_c, found_lv, nl;
	logic                 too_large, bad_free, has_free, root_hit;
	logic [MW-1:0]        cand, par_mask;
	logic                 go_left, desc_hit, buddy_free, g_ok;
	logic [IW-1:0]        nk, res_unit;

	assign accept = req.valid && req.ready;
	assign load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);

	assign total = TW'(req.request_size) + TW'(header_q);

	always_comb begin
		need_c = '0;
		for (int i = LEVEL_COUNT; i >= 1; i--) begin
			if (total <= (TW'(1) << (i + UNIT_BITS))) begin
				need_c = LW'(i);
			end
		end
	end

	assign too_large = (need_c == '0);
	assign bad_free = (((OW + 1)'(req.free_offset) >> RW) != '0) ||
		((req.free_offset & ALIGN_MASK) != '0);

	assign cand = m_rdata & ~(lvl_bit(need_q) - MW'(1));
	assign has_free = |cand;

	always_comb begin
		found_lv = '0;
		for (int i = LEVEL_COUNT; i >= 1; i--) begin
			if (cand[i-1]) begin
				found_lv = LW'(i);
			end
		end
	end

	assign root_hit = (found_lv == TOP_LVL);
	assign go_left = |(m_rdata & lvl_bit(fl_q));
	assign nl = lvl_q - LW'(1);
	assign nk = (idx_q << 1) | IW'(!go_left);
	assign desc_hit = (nl == fl_q);
	assign par_mask = mask_q | m_rdata;
	assign buddy_free = |(m_rdata & lvl_bit(lvl_q));
	assign g_ok = (g_rdata != '0) && (g_rdata <= TOP_LVL);
	assign res_unit = IW'(res_off_q >> (UNIT_BITS + 1));
	assign g_raddr = IW'(req.free_offset >> (UNIT_BITS + 1));

	always_comb begin
		state_d = state_q;
		rd_lv = TOP_LVL;
		rd_k = '0;
		m_we = 1'b0;
		wr_lv = lvl_q;
		wr_k = idx_q;
		m_wd = '0;
		g_we = 1'b0;
		g_waddr = res_unit;
		g_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				m_we = 1'b1;
				m_wd = (clr_q == '0) ? lvl_bit(TOP_LVL) : '0;
				g_we = (clr_q < AW'(UNIT_COUNT));
				g_waddr = clr_q[IW-1:0];
				if (clr_q == AW'(NODE_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.command == bba_pkg::CMD_ALLOC) begin
						state_d = too_large ? S_DONE : S_AEV;
					end else begin
						state_d = bad_free ? S_DONE : S_FEV;
					end
				end
			end
			S_AEV: begin
				if (!has_free) begin
					state_d = S_DONE;
				end else if (root_hit) begin
					state_d = S_SPL;
				end else begin
					rd_lv = TOP_LVL - LW'(1);
					state_d = S_DESC;
				end
			end
			S_DESC: begin
				if (desc_hit) begin
					state_d = S_SPL;
				end else begin
					rd_lv = nl - LW'(1);
					rd_k = nk << 1;
				end
			end
			S_SPL: begin
				m_we = 1'b1;
				m_wd = lvl_bit(lvl_q) - lvl_bit(need_q);
				if (lvl_q == need_q) begin
					g_we = 1'b1;
					g_waddr = IW'(idx_q << (need_q - LW'(1)));
					g_wdata = need_q;
					state_d = S_ASCR;
				end else begin
					state_d = S_SPR;
				end
			end
			S_SPR: begin
				m_we = 1'b1;
				wr_lv = lvl_q - LW'(1);
				wr_k = (idx_q << 1) | IW'(1);
				m_wd = lvl_bit(lvl_q - LW'(1));
				state_d = S_SPL;
			end
			S_ASCR: begin
				rd_lv = lvl_q;
				rd_k = idx_q ^ IW'(1);
				state_d = (lvl_q == TOP_LVL) ? S_DONE : S_ASC;
			end
			S_ASC: begin
				m_we = 1'b1;
				wr_lv = lvl_q + LW'(1);
				wr_k = idx_q >> 1;
				m_wd = par_mask;
				rd_lv = lvl_q + LW'(1);
				rd_k = (idx_q >> 1) ^ IW'(1);
				if (lvl_q + LW'(1) == TOP_LVL) begin
					state_d = S_DONE;
				end
			end
			S_FEV: begin
				if (g_ok) begin
					g_we = 1'b1;
					state_d = S_CRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CRD: begin
				m_we = 1'b1;
				rd_lv = lvl_q;
				rd_k = idx_q ^ IW'(1);
				if (lvl_q == TOP_LVL) begin
					m_wd = lvl_bit(lvl_q);
					state_d = S_ASCR;
				end else begin
					state_d = S_CEV;
				end
			end
			S_CEV: begin
				m_we = 1'b1;
				if (buddy_free) begin
					wr_k = idx_q ^ IW'(1);
					state_d = S_CRD;
				end else begin
					m_wd = lvl_bit(lvl_q);
					state_d = S_ASCR;
				end
			end
			S_DONE: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_waddr = (state_q == S_CLR) ? clr_q : node_addr(wr_lv, wr_k);
	assign m_raddr = node_addr(rd_lv, rd_k);

	// one mask per tree node: bit i-1 set when level i has a free block in the subtree
	bba_ram #(.WIDTH(MW), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wd),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	// level of the allocated block starting at each unit, zero when none
	bba_ram #(.WIDTH(LW), .DEPTH(UNIT_COUNT)) u_level_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			header_q <= bba_pkg::HDR_RESET;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (psel && penable && pwrite && paddr == bba_pkg::REG_HEADER) begin
				header_q <= pwdata[bba_pkg::HDR_W-1:0];
			end
			if (state_q == S_SPL && lvl_q == need_q) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == S_FEV && g_ok && cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					need_q <= need_c;
					res_st_q <= req.command == bba_pkg::CMD_ALLOC ? bba_pkg::ST_TOO_LARGE :
						bba_pkg::ST_BAD_FREE;
					res_lvl_q <= '0;
					res_off_q <= (req.command == bba_pkg::CMD_FREE && !bad_free) ?
						req.free_offset : '0;
				end
			end
			S_AEV: begin
				fl_q <= found_lv;
				lvl_q <= TOP_LVL;
				idx_q <= '0;
				fidx_q <= '0;
				res_st_q <= bba_pkg::ST_NO_FREE;
			end
			S_DESC: begin
				lvl_q <= nl;
				idx_q <= nk;
				fidx_q <= nk;
			end
			S_SPL: begin
				if (lvl_q == need_q) begin
					res_st_q <= bba_pkg::ST_OK;
					res_off_q <= OW'(RW'(idx_q) << (need_q + LW'(UNIT_BITS)));
					res_lvl_q <= need_q;
					lvl_q <= fl_q;
					idx_q <= fidx_q;
					mask_q <= lvl_bit(fl_q) - lvl_bit(need_q);
				end
			end
			S_SPR: begin
				lvl_q <= lvl_q - LW'(1);
				idx_q <= idx_q << 1;
			end
			S_ASC: begin
				mask_q <= par_mask;
				lvl_q <= lvl_q + LW'(1);
				idx_q <= idx_q >> 1;
			end
			S_FEV: begin
				if (g_ok) begin
					res_st_q <= bba_pkg::ST_OK;
					res_lvl_q <= g_rdata;
					lvl_q <= g_rdata;
					idx_q <= IW'(res_off_q >> (g_rdata + LW'(UNIT_BITS)));
				end else begin
					res_off_q <= '0;
				end
			end
			S_CRD: begin
				if (lvl_q == TOP_LVL) begin
					mask_q <= lvl_bit(lvl_q);
				end
			end
			S_CEV: begin
				if (buddy_free) begin
					lvl_q <= lvl_q + LW'(1);
					idx_q <= idx_q >> 1;
				end else begin
					mask_q <= lvl_bit(lvl_q);
				end
			end
			S_DONE: begin
				if (load) begin
					out_st_q <= res_st_q;
					out_off_q <= res_off_q;
					out_lvl_q <= res_lvl_q;
					out_cnt_q <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = out_st_q;
	assign rsp.block_offset = out_off_q;
	assign rsp.block_level = bba_pkg::LVL_W'(out_lvl_q);
	assign rsp.blocks_in_use = bba_pkg::CNT_W'(out_cnt_q);

	assign prdata = bba_pkg::APB_DW'(header_q);
	assign pready = 1'b1;

	a_desc_above_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DESC) |-> (lvl_q > fl_q))
		else $error("descent reached the target level without stopping");

	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPL) |-> (need_q != '0 && lvl_q >= need_q))
		else $error("split walked below the requested level");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != bba_pkg::ST_OK) |->
		(rsp.block_level == '0 && rsp.block_offset == '0))
		else $error("error response carries a block");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (cnt_q <= CW'(UNIT_COUNT)))
		else $error("blocks in use exceeds unit count");

endmodule

/* tb/buddy_block_allocator_core_tb.sv */
`timescale 1ns / 1ps

module buddy_block_allocator_core_tb;
	import bba_pkg::*;

	localparam int LEVELS = 9;
	localparam int UNIT_BITS = 4;
	localparam int NODES = (1 << LEVELS) - 1;
	localparam int UNITS = 1 << (LEVELS - 1);
	localparam int HOLD_AT_ITEM = 40;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		status_t st;
		offset_t off;
		level_t  lvl;
		count_t  used;
	} grant_t;

	typedef struct packed {
		logic    cfg;
		logic    cmd;
		size_t   size;
		offset_t off;
		logic    typed;
		grant_t  want;
	} plan_row_t;

	localparam plan_row_t PLAN [28] = '{
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b1, '{ST_BAD_FREE,  13'd0,  4'd0, 9'd0}},
		'{1'b0, CMD_ALLOC, 14'd8192, 13'd0,    1'b1, '{ST_TOO_LARGE, 13'd0,  4'd0, 9'd0}},
		'{1'b0, CMD_ALLOC, 14'd0,    13'd0,    1'b1, '{ST_OK,        13'd0,  4'd1, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd8191, 1'b1, '{ST_BAD_FREE,  13'd0,  4'd0, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd16,   1'b1, '{ST_BAD_FREE,  13'd0,  4'd0, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd32,   1'b1, '{ST_BAD_FREE,  13'd0,  4'd0, 9'd1}},
		'{1'b0, CMD_ALLOC, 14'd8160, 13'd0,    1'b1, '{ST_NO_FREE,   13'd0,  4'd0, 9'd1}},
		'{1'b0, CMD_ALLOC, 14'd1,    13'd0,    1'b0, '0},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b1, '{ST_OK,        13'd0,  4'd1, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b1, '{ST_BAD_FREE,  13'd0,  4'd0, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd64,   1'b1, '{ST_OK,        13'd64, 4'd2, 9'd0}},
		'{1'b0, CMD_ALLOC, 14'd8160, 13'd0,    1'b1, '{ST_OK,        13'd0,  4'd9, 9'd1}},
		'{1'b0, CMD_ALLOC, 14'd0,    13'd0,    1'b1, '{ST_NO_FREE,   13'd0,  4'd0, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b1, '{ST_OK,        13'd0,  4'd9, 9'd0}},
		'{1'b1, CMD_ALLOC, 14'd0,    13'd0,    1'b0, '0},
		'{1'b0, CMD_ALLOC, 14'd8192, 13'd0,    1'b1, '{ST_OK,        13'd0,  4'd9, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b1, '{ST_OK,        13'd0,  4'd9, 9'd0}},
		'{1'b0, CMD_ALLOC, 14'd32,   13'd0,    1'b1, '{ST_OK,        13'd0,  4'd1, 9'd1}},
		'{1'b0, CMD_ALLOC, 14'd33,   13'd0,    1'b0, '0},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b0, '0},
		'{1'b0, CMD_FREE,  14'd0,    13'd64,   1'b0, '0},
		'{1'b1, CMD_ALLOC, 14'd255,  13'd0,    1'b0, '0},
		'{1'b0, CMD_ALLOC, 14'd7937, 13'd0,    1'b1, '{ST_OK,        13'd0,  4'd9, 9'd1}},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b1, '{ST_OK,        13'd0,  4'd9, 9'd0}},
		'{1'b0, CMD_ALLOC, 14'd7938, 13'd0,    1'b1, '{ST_TOO_LARGE, 13'd0,  4'd0, 9'd0}},
		'{1'b0, CMD_ALLOC, 14'd0,    13'd0,    1'b0, '0},
		'{1'b0, CMD_FREE,  14'd0,    13'd0,    1'b0, '0},
		'{1'b1, CMD_ALLOC, 14'd32,   13'd0,    1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	bba_req_if req_ch();
	bba_rsp_if rsp_ch();

	buddy_block_allocator_core #(
		.LEVEL_COUNT(LEVELS),
		.UNIT_BITS(UNIT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic free_map [NODES];
	level_t owner_level [UNITS];
	int in_use;
	header_t hdr_now;

	grant_t pending_grants [$];
	offset_t held_blocks [$];
	int failures = 0;
	int items_sent = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit hold_request = 0;
	int status_hits [4] = '{0, 0, 0, 0};
	int peak_in_use = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int node_of(int lv, int k);
		return ((1 << (LEVELS - lv)) - 1) + k;
	endfunction

	function automatic grant_t apply_request(logic cmd, size_t size, offset_t off);
		int total;
		int need;
		int lv;
		int k;
		int given;
		int unit;
		if (cmd == CMD_ALLOC) begin
			total = int'(size) + int'(hdr_now);
			need = 1;
			while (need <= LEVELS && total > (1 << (need + UNIT_BITS)))
				need++;
			if (need > LEVELS)
				return '{ST_TOO_LARGE, '0, '0, count_t'(in_use)};
			for (int l = need; l <= LEVELS; l++) begin
				for (int b = 0; b < (1 << (LEVELS - l)); b++) begin
					if (!free_map[node_of(l, b)])
						continue;
					free_map[node_of(l, b)] = 1'b0;
					lv = l;
					k = b;
					while (lv > need) begin
						lv--;
						k = k << 1;
						free_map[node_of(lv, k + 1)] = 1'b1;
					end
					off = offset_t'(k << (need + UNIT_BITS));
					owner_level[off >> (UNIT_BITS + 1)] = level_t'(need);
					in_use++;
					return '{ST_OK, off, level_t'(need), count_t'(in_use)};
				end
			end
			return '{ST_NO_FREE, '0, '0, count_t'(in_use)};
		end
		if (off[UNIT_BITS:0] != '0)
			return '{ST_BAD_FREE, '0, '0, count_t'(in_use)};
		unit = int'(off >> (UNIT_BITS + 1));
		lv = int'(owner_level[unit]);
		if (lv == 0 || lv > LEVELS)
			return '{ST_BAD_FREE, '0, '0, count_t'(in_use)};
		given = lv;
		owner_level[unit] = '0;
		k = int'(off) >> (lv + UNIT_BITS);
		while (lv < LEVELS && free_map[node_of(lv, k ^ 1)]) begin
			free_map[node_of(lv, k ^ 1)] = 1'b0;
			k = k >> 1;
			lv++;
		end
		free_map[node_of(lv, k)] = 1'b1;
		if (in_use > 0)
			in_use--;
		return '{ST_OK, off, level_t'(given), count_t'(in_use)};
	endfunction

	task automatic send_request(input logic cmd, input size_t size, input offset_t off,
			input logic typed, input grant_t want);
		grant_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.request_size <= size;
		req_ch.free_offset <= off;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_request(cmd, size, off);
		pending_grants.push_back(typed ? want : predicted);
		if (predicted.st == ST_OK) begin
			if (cmd == CMD_ALLOC) begin
				held_blocks.push_back(predicted.off);
			end else begin
				foreach (held_blocks[i])
					if (held_blocks[i] == off) begin
						held_blocks.delete(i);
						break;
					end
			end
		end
		items_sent++;
		if (items_sent == HOLD_AT_ITEM)
			hold_request = 1'b1;
	endtask

	task automatic random_request(input int alloc_pct, input int noise_pct, input int size_cap);
		int r;
		int pick;
		size_t size;
		r = $urandom_range(99);
		if (r < noise_pct) begin
			pick = $urandom_range(2);
			if (pick == 0)
				send_request(CMD_FREE, size_t'($urandom), offset_t'($urandom), 1'b0, '0);
			else if (pick == 1)
				send_request(CMD_FREE, '0, offset_t'($urandom) & ~offset_t'(31), 1'b0, '0);
			else
				send_request(CMD_ALLOC, size_t'($urandom_range(8192, 4096)), '0, 1'b0, '0);
		end else if (r < noise_pct + alloc_pct || held_blocks.size() == 0) begin
			pick = $urandom_range(99);
			if (size_cap > 0)
				size = size_t'($urandom_range(size_cap));
			else if (pick < 55)
				size = size_t'($urandom_range(64));
			else if (pick < 85)
				size = size_t'($urandom_range(512));
			else if (pick < 97)
				size = size_t'($urandom_range(2048));
			else
				size = size_t'($urandom_range(8192));
			send_request(CMD_ALLOC, size, offset_t'($urandom), 1'b0, '0);
		end else begin
			send_request(CMD_FREE, size_t'($urandom),
				held_blocks[$urandom_range(held_blocks.size() - 1)], 1'b0, '0);
		end
	endtask

	task automatic release_all();
		while (held_blocks.size() != 0)
			send_request(CMD_FREE, size_t'($urandom),
				held_blocks[$urandom_range(held_blocks.size() - 1)], 1'b0, '0);
	endtask

	task automatic apb_access(input logic wr, input header_t value, output logic [APB_DW-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_HEADER;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_header(input header_t value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd !== APB_DW'(value)) begin
			$display("%0t: header_bytes read expected %0d got %0d", $time, value, rd);
			failures++;
		end
	endtask

	task automatic set_header(input header_t value);
		logic [APB_DW-1:0] rd;
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		apb_access(1'b1, value, rd);
		hdr_now = value;
		check_header(value);
	endtask

	always @(posedge clk) begin : response_side
		int hold_left;
		grant_t want;
		grant_t got;
		bit bad;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.status, rsp_ch.block_offset, rsp_ch.block_level, rsp_ch.blocks_in_use};
			if (pending_grants.size() == 0) begin
				$display("%0t: response with nothing expected, got %p", $time, got);
				failures++;
			end else begin
				want = pending_grants.pop_front();
				bad = 1'b0;
				if (got.st !== want.st) begin
					$display("%0t: status expected %0d got %0d", $time, want.st, got.st);
					bad = 1'b1;
				end
				if (got.off !== want.off) begin
					$display("%0t: block_offset expected %0d got %0d", $time, want.off, got.off);
					bad = 1'b1;
				end
				if (got.lvl !== want.lvl) begin
					$display("%0t: block_level expected %0d got %0d", $time, want.lvl, got.lvl);
					bad = 1'b1;
				end
				if (got.used !== want.used) begin
					$display("%0t: blocks_in_use expected %0d got %0d", $time, want.used,
						got.used);
					bad = 1'b1;
				end
				if (bad)
					failures++;
				status_hits[want.st]++;
				if (int'(want.used) > peak_in_use)
					peak_in_use = int'(want.used);
			end
		end
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		int extra;
		int wait_cycles;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.request_size = '0;
		req_ch.free_offset = '0;
		rsp_ch.ready = 1'b0;
		foreach (free_map[i])
			free_map[i] = 1'b0;
		foreach (owner_level[i])
			owner_level[i] = '0;
		free_map[node_of(LEVELS, 0)] = 1'b1;
		in_use = 0;
		hdr_now = HDR_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_header(HDR_RESET);

		src_idle_pct = 16;
		snk_idle_pct = 64;
		foreach (PLAN[i]) begin
			if (PLAN[i].cfg)
				set_header(header_t'(PLAN[i].size));
			else
				send_request(PLAN[i].cmd, PLAN[i].size, PLAN[i].off, PLAN[i].typed,
					PLAN[i].want);
		end
		repeat (100)
			random_request(60, 10, 0);
		release_all();

		set_header(8'd0);
		src_idle_pct = 64;
		snk_idle_pct = 16;
		extra = 0;
		for (int n = 0; n < 330 && extra < 6; n++) begin
			random_request(95, 5, 32);
			if (in_use == UNITS)
				extra++;
		end
		release_all();

		set_header(8'd255);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (80)
			random_request(55, 10, 0);
		req_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (pending_grants.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (pending_grants.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, pending_grants.size());
			failures += pending_grants.size();
		end

		$display("ran %0d requests: %0d ok, %0d too large, %0d exhausted, %0d bad frees",
			items_sent, status_hits[ST_OK], status_hits[ST_TOO_LARGE],
			status_hits[ST_NO_FREE], status_hits[ST_BAD_FREE]);
		$display("header settings 32, 0 and 255 used; peak of %0d blocks in use", peak_in_use);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
design/bba_pkg.sv
design/bba_if.sv
design/bba_ram.sv
design/buddy_block_allocator_core.sv
tb/buddy_block_allocator_core_tb.sv
